@@ design/haar_wavelet_top_k_macros.svh @@
// Assertion helpers for the wavelet block, clocked on clk_i, off while in reset.
`ifndef HAAR_WAVELET_TOP_K_MACROS_SVH
`define HAAR_WAVELET_TOP_K_MACROS_SVH

// Check a property that holds in the same cycle.
`define HWT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hwt: assertion failed");

// Check that a condition implies another in the next cycle.
`define HWT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hwt: assertion failed in next cycle");

`endif

@@ design/hwt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hwt_pkg;

  localparam int N_SAMPLES = 64;
  localparam int LOG_N     = 6;
  localparam int TREE_AW   = LOG_N + 1;
  localparam int VAL_W     = 48;
  localparam int SMP_W     = 32;
  localparam int KEEP_W    = 7;
  localparam int WIDE_W    = VAL_W + 3;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(8);
  localparam logic signed [17:0] SQRT2_Q16 = 18'sd92682;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_ZFILL = 10'b0000000010,
    ST_RDL   = 10'b0000000100,
    ST_RDR   = 10'b0000001000,
    ST_SUM   = 10'b0000010000,
    ST_MUL   = 10'b0000100000,
    ST_FIN   = 10'b0001000000,
    ST_SCAN  = 10'b0010000000,
    ST_SLAST = 10'b0100000000,
    ST_EMIT  = 10'b1000000000
  } state_e;

  // Level scale exponent of a node: LOG_N minus the position of its top bit.
  function automatic logic [2:0] node_exp(input logic [LOG_N-1:0] node);
    logic [2:0] msb;
    msb = 3'd0;
    for (int b = 0; b < LOG_N; b++) begin
      if (node[b]) begin
        msb = 3'(b);
      end
    end
    return 3'(LOG_N) - msb;
  endfunction

  function automatic val_t sat_val(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'({1'b0, {(VAL_W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      return val_t'(hi);
    end else if (v < lo) begin
      return val_t'(lo);
    end
    return val_t'(v);
  endfunction

endpackage
`default_nettype wire

@@ design/haar_wavelet_top_k.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel      | Ports                                        | Handshake
// -------------+----------------------------------------------+------------------------------
// sample in    | sample_i, last_sample_i                      | start & !busy at clock edge
// coeff out    | coeff_value_o, coeff_index_o, last_coeff_o   | coeff_valid_o, one cycle
// keep_count   | keep_count_i                                 | keep_count_we_i at clock edge
//
// A sample word that does not close a block is written straight into the tree; busy stays low.
// Closing a block zero-fills the missing leaves (one per cycle), then runs 63 tree
// nodes in turn through one shared scale unit (two reads of the single tree read
// port, sum, multiply, finish for average and again for difference).
// Selection scans all 64 slots once per emitted word.
// Reset clears control state and the emitted marks; keep_count returns to 8.
// The receiver cannot stall: each coefficient word is shown for exactly one cycle.
module haar_wavelet_top_k (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start,
  output logic                                 busy,
  input  wire  signed [hwt_pkg::SMP_W-1:0]     sample_i,
  input  wire                                  last_sample_i,
  input  wire                                  keep_count_we_i,
  input  wire         [hwt_pkg::KEEP_W-1:0]    keep_count_i,
  output logic                                 coeff_valid_o,
  output logic signed [hwt_pkg::VAL_W-1:0]     coeff_value_o,
  output logic        [hwt_pkg::LOG_N-1:0]     coeff_index_o,
  output logic                                 last_coeff_o
);

  localparam int NW = hwt_pkg::LOG_N;
  localparam int AW = hwt_pkg::TREE_AW;
  localparam int VW = hwt_pkg::VAL_W;
  localparam int WW = hwt_pkg::WIDE_W;
  localparam int KW = hwt_pkg::KEEP_W;
  localparam logic [NW-1:0] NODE_TOP = {NW{1'b1}};
  localparam logic [KW-1:0] K_MAX    = KW'(hwt_pkg::N_SAMPLES);

  hwt_pkg::state_e state_q, state_d;

  logic [KW-1:0] keep_q, keep_d;
  logic [KW-1:0] k_q, k_d;
  logic [KW-1:0] n_q, n_d;
  logic [NW-1:0] lc_q, lc_d;
  logic [NW-1:0] node_q, node_d;
  logic          ph_q, ph_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          pv_q, pv_d;
  logic [NW-1:0] pj_q, pj_d;
  logic          found_q, found_d;
  logic [hwt_pkg::N_SAMPLES-1:0] mark_q, mark_d;

  hwt_pkg::val_t left_q, left_d;
  hwt_pkg::val_t op_q, op_d;
  hwt_pkg::val_t dif_q, dif_d;
  hwt_pkg::val_t best_val_q, best_val_d;
  logic [NW-1:0] best_idx_q, best_idx_d;
  logic signed [49:0] phi_q, phi_d;
  logic        [32:0] plo_q, plo_d;

  logic          out_vld_q, out_vld_d;
  hwt_pkg::val_t out_val_q, out_val_d;
  logic [NW-1:0] out_idx_q, out_idx_d;
  logic          out_last_q, out_last_d;

  // tree memory: leaves in the upper half, nodes below
  hwt_pkg::val_t tree_mem [2**AW];
  logic          tree_we;
  logic [AW-1:0] tree_waddr, tree_raddr;
  hwt_pkg::val_t tree_wdata, tree_rdata;

  // coefficient memory, one slot per node plus the root average
  hwt_pkg::val_t diff_mem [2**NW];
  logic          diff_we;
  logic [NW-1:0] diff_waddr;
  hwt_pkg::val_t diff_wdata, diff_rdata;

  always_ff @(posedge clk_i) begin
    if (tree_we) begin
      tree_mem[tree_waddr] <= tree_wdata;
    end
    tree_rdata <= tree_mem[tree_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (diff_we) begin
      diff_mem[diff_waddr] <= diff_wdata;
    end
    diff_rdata <= diff_mem[cnt_q];
  end

  // shared scale unit: finish stage of sqrt(2^e) with saturation
  logic [2:0]              exp_w;
  logic signed [WW-1:0]    pre_w;
  hwt_pkg::val_t           mid_w;
  logic signed [WW-1:0]    shl_w;
  hwt_pkg::val_t           res_w;
  logic signed [VW:0]      sum_w, sub_w;
  logic                    take_w;

  always_comb begin
    exp_w = hwt_pkg::node_exp(node_q);
    if (exp_w[0]) begin
      pre_w = WW'(phi_q) + WW'(plo_q[32:16]);
    end else begin
      pre_w = WW'(op_q);
    end
    mid_w = hwt_pkg::sat_val(pre_w);
    shl_w = WW'(mid_w) <<< exp_w[2:1];
    res_w = hwt_pkg::sat_val(shl_w);
    sum_w = (VW+1)'(tree_rdata) + (VW+1)'(left_q);
    sub_w = (VW+1)'(tree_rdata) - (VW+1)'(left_q);
    take_w = pv_q && !mark_q[pj_q] && (!found_q || (diff_rdata > best_val_q));
  end

  always_comb begin
    state_d    = state_q;
    keep_d     = keep_q;
    k_d        = k_q;
    n_d        = n_q;
    lc_d       = lc_q;
    node_d     = node_q;
    ph_d       = ph_q;
    cnt_d      = cnt_q;
    pv_d       = pv_q;
    pj_d       = pj_q;
    found_d    = found_q;
    mark_d     = mark_q;
    left_d     = left_q;
    op_d       = op_q;
    dif_d      = dif_q;
    best_val_d = best_val_q;
    best_idx_d = best_idx_q;
    phi_d      = phi_q;
    plo_d      = plo_q;
    out_vld_d  = 1'b0;
    out_val_d  = out_val_q;
    out_idx_d  = out_idx_q;
    out_last_d = out_last_q;
    tree_we    = 1'b0;
    tree_waddr = {1'b1, lc_q};
    tree_wdata = VW'(sample_i);
    tree_raddr = {node_q, 1'b0};
    diff_we    = 1'b0;
    diff_waddr = node_q;
    diff_wdata = res_w;

    if (keep_count_we_i) begin
      keep_d = keep_count_i;
    end

    case (state_q)
      hwt_pkg::ST_IDLE: begin
        if (start) begin
          tree_we = 1'b1;
          if (lc_q == NODE_TOP) begin
            lc_d    = '0;
            node_d  = NODE_TOP;
            ph_d    = 1'b0;
            state_d = hwt_pkg::ST_RDL;
          end else begin
            lc_d = lc_q + 1'b1;
            if (last_sample_i) begin
              state_d = hwt_pkg::ST_ZFILL;
            end
          end
        end
      end
      hwt_pkg::ST_ZFILL: begin
        // pad the short block with zero leaves
        tree_we    = 1'b1;
        tree_wdata = '0;
        if (lc_q == NODE_TOP) begin
          lc_d    = '0;
          node_d  = NODE_TOP;
          ph_d    = 1'b0;
          state_d = hwt_pkg::ST_RDL;
        end else begin
          lc_d = lc_q + 1'b1;
        end
      end
      hwt_pkg::ST_RDL: begin
        tree_raddr = {node_q, 1'b0};
        state_d    = hwt_pkg::ST_RDR;
      end
      hwt_pkg::ST_RDR: begin
        tree_raddr = {node_q, 1'b1};
        left_d     = tree_rdata;
        state_d    = hwt_pkg::ST_SUM;
      end
      hwt_pkg::ST_SUM: begin
        op_d    = hwt_pkg::val_t'(sum_w >>> 1);
        dif_d   = hwt_pkg::val_t'(sub_w >>> 1);
        state_d = hwt_pkg::ST_MUL;
      end
      hwt_pkg::ST_MUL: begin
        phi_d   = $signed(op_q[VW-1:16]) * hwt_pkg::SQRT2_Q16;
        plo_d   = op_q[15:0] * 17'(hwt_pkg::SQRT2_Q16);
        state_d = hwt_pkg::ST_FIN;
      end
      hwt_pkg::ST_FIN: begin
        if (!ph_q) begin
          tree_we    = 1'b1;
          tree_waddr = {1'b0, node_q};
          tree_wdata = res_w;
          if (node_q == NW'(1)) begin
            diff_we    = 1'b1;
            diff_waddr = '0;
          end
          op_d    = dif_q;
          ph_d    = 1'b1;
          state_d = hwt_pkg::ST_MUL;
        end else begin
          diff_we = 1'b1;
          ph_d    = 1'b0;
          if (node_q == NW'(1)) begin
            // clamp the count and start the first selection pass
            if (keep_q == '0) begin
              k_d = KW'(1);
            end else if (keep_q > K_MAX) begin
              k_d = K_MAX;
            end else begin
              k_d = keep_q;
            end
            n_d     = '0;
            mark_d  = '0;
            cnt_d   = '0;
            pv_d    = 1'b0;
            found_d = 1'b0;
            state_d = hwt_pkg::ST_SCAN;
          end else begin
            node_d  = node_q - 1'b1;
            state_d = hwt_pkg::ST_RDL;
          end
        end
      end
      hwt_pkg::ST_SCAN, hwt_pkg::ST_SLAST: begin
        if (take_w) begin
          best_val_d = diff_rdata;
          best_idx_d = pj_q;
          found_d    = 1'b1;
        end
        if (state_q == hwt_pkg::ST_SCAN) begin
          pv_d  = 1'b1;
          pj_d  = cnt_q;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == NODE_TOP) begin
            state_d = hwt_pkg::ST_SLAST;
          end
        end else begin
          pv_d    = 1'b0;
          state_d = hwt_pkg::ST_EMIT;
        end
      end
      hwt_pkg::ST_EMIT: begin
        out_vld_d          = 1'b1;
        out_val_d          = best_val_q;
        out_idx_d          = best_idx_q;
        out_last_d         = (n_q + 1'b1) == k_q;
        mark_d[best_idx_q] = 1'b1;
        n_d                = n_q + 1'b1;
        cnt_d              = '0;
        found_d            = 1'b0;
        if ((n_q + 1'b1) == k_q) begin
          state_d = hwt_pkg::ST_IDLE;
        end else begin
          state_d = hwt_pkg::ST_SCAN;
        end
      end
      default: begin
        state_d = hwt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hwt_pkg::ST_IDLE;
      keep_q    <= hwt_pkg::KEEP_RESET;
      k_q       <= KW'(1);
      n_q       <= '0;
      lc_q      <= '0;
      node_q    <= '0;
      ph_q      <= 1'b0;
      cnt_q     <= '0;
      pv_q      <= 1'b0;
      pj_q      <= '0;
      found_q   <= 1'b0;
      mark_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      keep_q    <= keep_d;
      k_q       <= k_d;
      n_q       <= n_d;
      lc_q      <= lc_d;
      node_q    <= node_d;
      ph_q      <= ph_d;
      cnt_q     <= cnt_d;
      pv_q      <= pv_d;
      pj_q      <= pj_d;
      found_q   <= found_d;
      mark_q    <= mark_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    left_q     <= left_d;
    op_q       <= op_d;
    dif_q      <= dif_d;
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    phi_q      <= phi_d;
    plo_q      <= plo_d;
    out_val_q  <= out_val_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign busy          = (state_q != hwt_pkg::ST_IDLE);
  assign coeff_valid_o = out_vld_q;
  assign coeff_value_o = out_val_q;
  assign coeff_index_o = out_idx_q;
  assign last_coeff_o  = out_last_q;

`include "haar_wavelet_top_k_macros.svh"

  // more words follow a word that is not the last, so hold busy
  `HWT_ASSERT(a_more_busy, !(coeff_valid_o && !last_coeff_o) || busy)
  // the final word leaves the block ready for a new block
  `HWT_ASSERT(a_last_idle, !(coeff_valid_o && last_coeff_o) || !busy)
  // no word is shown right after a sample is taken
  `HWT_ASSERT_NEXT(a_load_quiet, start && !busy, !coeff_valid_o)

endmodule
`default_nettype wire
